FILE: rtl/pbp_pkg.sv
// Shared types and codes for the page buffer pool.
// Used by pbp_free_list, pbp_directory and page_buffer_pool_with_pin_counts.
package pbp_pkg;

	localparam int BUF_W  = 10;
	localparam int PAGE_W = 32;
	localparam int CFG_W  = 11;

	typedef enum logic [2:0] {
		CMD_INIT     = 3'd0,
		CMD_CLEAR    = 3'd1,
		CMD_ACQUIRE  = 3'd2,
		CMD_RELEASE  = 3'd3,
		CMD_ENTER    = 3'd4,
		CMD_CONTAINS = 3'd5,
		CMD_LEAVE    = 3'd6,
		CMD_ADD      = 3'd7
	} cmd_e_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_MISS      = 3'd1,
		STS_UNDERFLOW = 3'd2,
		STS_DIR_FULL  = 3'd3,
		STS_FREE_FULL = 3'd4
	} status_e_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_CLEAR,
		ST_SCAN,
		ST_EXEC,
		ST_POP,
		ST_POPW,
		ST_PUSH,
		ST_DONE
	} state_e_t;

	// One directory slot, without its pin count.
	typedef struct packed {
		logic              valid;
		logic [PAGE_W-1:0] page;
		logic              has_buf;
		logic [BUF_W-1:0]  buffer;
	} slot_t;

	// Control of the free list memory and its fill count.
	typedef struct packed {
		logic write;
		logic push;
		logic pop;
		logic load;
	} fl_ctl_t;

	typedef struct packed {
		status_e_t         status;
		logic              found;
		logic              rvalid;
		logic [BUF_W-1:0]  rbuf;
		logic              zev;
		logic [PAGE_W-1:0] zpage;
	} res_t;

endpackage

FILE: rtl/pbp_free_list.sv
// Free list of buffer indices: a stack memory and its fill count.
// Depends on pbp_pkg.
module pbp_free_list #(
	parameter int NUM_BUFFERS = 1024,
	localparam int FA = $clog2(NUM_BUFFERS),
	localparam int FC = $clog2(NUM_BUFFERS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pbp_pkg::fl_ctl_t           ctl,
	input  logic [FA-1:0]              wr_addr,
	input  logic [pbp_pkg::BUF_W-1:0]  wr_data,
	input  logic [FC-1:0]              load_count,
	output logic [FC-1:0]              count,
	output logic [pbp_pkg::BUF_W-1:0]  rd_data
);
	import pbp_pkg::*;

	logic [BUF_W-1:0] mem [NUM_BUFFERS];
	logic [FC-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (ctl.write) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.pop) begin
			rd_data <= mem[FA'(count_q - FC'(1))];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.load) begin
			count_q <= load_count;
		end else if (ctl.push) begin
			count_q <= count_q + FC'(1);
		end else if (ctl.pop) begin
			count_q <= count_q - FC'(1);
		end
	end

	assign count = count_q;

endmodule

FILE: rtl/pbp_directory.sv
// Directory memory: one slot record and one pin count per slot.
// Depends on pbp_pkg. One read port with registered output, one write port.
module pbp_directory #(
	parameter int DIR_SLOTS = 1024,
	parameter int PIN_BITS = 16,
	localparam int SA = $clog2(DIR_SLOTS)
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [SA-1:0]        rd_addr,
	output pbp_pkg::slot_t       rd_slot,
	output logic [PIN_BITS-1:0]  rd_pins,
	input  logic                 wr_en,
	input  logic [SA-1:0]        wr_addr,
	input  pbp_pkg::slot_t       wr_slot,
	input  logic [PIN_BITS-1:0]  wr_pins
);
	import pbp_pkg::*;

	slot_t               slot_mem [DIR_SLOTS];
	logic [PIN_BITS-1:0] pin_mem  [DIR_SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_slot;
			pin_mem[wr_addr]  <= wr_pins;
		end
		if (rd_en) begin
			rd_slot <= slot_mem[rd_addr];
			rd_pins <= pin_mem[rd_addr];
		end
	end

endmodule

FILE: rtl/page_buffer_pool_with_pin_counts.sv
// Top level of the page buffer pool: command sequencer, APB register, result register.
// Depends on pbp_pkg, pbp_free_list and pbp_directory.
//
// A request on the input channel (in_valid/in_ready) carries one command; every
// command gives exactly one result on the output channel (out_valid/out_ready).
// The register pages_in_use sits at APB address 0 and must be written by the user
// only while idle; the block itself does not enforce this. Work per request:
//   acquire, release: free list memory read and update.
//   enter, contains, leave, add: the directory is searched one slot per cycle
//   through its single read port, stopping at a hit.
//   clear: one slot swept per cycle.
//   init: one entry written per cycle.
// After reset the block sweeps the directory to mark every slot empty, with
// in_ready low; register writes are taken meanwhile.
// One request is worked on at a time. A finished result waits in the output
// register while the next request is accepted; if the receiver stalls with a
// result still held, the next result waits until the register is taken.
module page_buffer_pool_with_pin_counts #(
	parameter int NUM_BUFFERS = 1024,
	parameter int DIR_SLOTS = 1024,
	parameter int PIN_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  cmd,
	input  logic [pbp_pkg::PAGE_W-1:0]  page_id,
	input  logic [pbp_pkg::BUF_W-1:0]   buffer_index,
	input  logic                        buffer_absent,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic                        found,
	output logic                        result_valid_buffer,
	output logic [pbp_pkg::BUF_W-1:0]   result_buffer,
	output logic                        zero_ref_event,
	output logic [pbp_pkg::PAGE_W-1:0]  zero_ref_page,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import pbp_pkg::*;

	localparam int SA   = $clog2(DIR_SLOTS);
	localparam int FA   = $clog2(NUM_BUFFERS);
	localparam int FC   = $clog2(NUM_BUFFERS + 1);
	localparam int MAXD = (DIR_SLOTS > NUM_BUFFERS) ? DIR_SLOTS : NUM_BUFFERS;
	localparam int SW   = $clog2(MAXD + 1);
	localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

	state_e_t            state_q, state_d;
	logic                wipe_q;
	logic [FC-1:0]       fill_n_q;
	logic [SW-1:0]       sweep_q;
	logic [CFG_W-1:0]    pages_q;
	logic                rd_v_s1;
	logic [SA-1:0]       rd_addr_s1;
	logic                hit_q, free_ok_q;
	logic [SA-1:0]       hit_idx_q, free_idx_q;
	slot_t               hit_slot_q;
	logic [PIN_BITS-1:0] hit_pins_q;
	cmd_e_t              cmd_q;
	logic [PAGE_W-1:0]   page_q;
	logic [BUF_W-1:0]    bidx_q;
	logic                absent_q;
	res_t                res_q, out_res_q;
	logic                out_valid_q;

	logic                accept, out_load, issue, init_end, scan_hit, scan_last;
	logic                sweep_step;
	logic [FC-1:0]       fill_n;
	fl_ctl_t             fl_ctl;
	logic [FA-1:0]       fl_wr_addr;
	logic [BUF_W-1:0]    fl_wr_data;
	logic [FC-1:0]       fl_count;
	logic [BUF_W-1:0]    fl_rd_data;
	logic                fl_full;
	logic                dir_rd_en, dir_wr_en;
	logic [SA-1:0]       dir_wr_addr;
	slot_t               dir_wr_slot, rd_slot;
	logic [PIN_BITS-1:0] dir_wr_pins, rd_pins;

	pbp_free_list #(.NUM_BUFFERS(NUM_BUFFERS)) u_free (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (fl_ctl),
		.wr_addr    (fl_wr_addr),
		.wr_data    (fl_wr_data),
		.load_count (fill_n_q),
		.count      (fl_count),
		.rd_data    (fl_rd_data)
	);

	pbp_directory #(.DIR_SLOTS(DIR_SLOTS), .PIN_BITS(PIN_BITS)) u_dir (
		.clk     (clk),
		.rd_en   (dir_rd_en),
		.rd_addr (sweep_q[SA-1:0]),
		.rd_slot (rd_slot),
		.rd_pins (rd_pins),
		.wr_en   (dir_wr_en),
		.wr_addr (dir_wr_addr),
		.wr_slot (dir_wr_slot),
		.wr_pins (dir_wr_pins)
	);

	assign accept     = in_valid && in_ready;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign fl_full    = (fl_count == FC'(NUM_BUFFERS));
	assign issue      = (sweep_q < SW'(DIR_SLOTS));
	assign init_end   = !issue && (sweep_q >= SW'(fill_n_q));
	assign scan_hit   = rd_v_s1 && rd_slot.valid && (rd_slot.page == page_q);
	assign scan_last  = rd_v_s1 && (rd_addr_s1 == SA'(DIR_SLOTS - 1));
	assign fill_n     = (32'(pages_q) < NUM_BUFFERS) ? FC'(pages_q) : FC'(NUM_BUFFERS);
	assign sweep_step = (state_q == ST_CLEAR)
		|| (state_q == ST_SCAN && !scan_hit && !scan_last);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (cmd_e_t'(cmd))
						CMD_INIT:    state_d = ST_INIT;
						CMD_CLEAR:   state_d = ST_CLEAR;
						CMD_ACQUIRE: state_d = ST_POP;
						CMD_RELEASE: state_d = ST_PUSH;
						default:     state_d = ST_SCAN;
					endcase
				end
			end
			ST_INIT:  if (init_end) state_d = wipe_q ? ST_IDLE : ST_DONE;
			ST_CLEAR: if (scan_last) state_d = ST_DONE;
			ST_SCAN:  if (scan_hit || scan_last) state_d = ST_EXEC;
			ST_POP:   state_d = (fl_count == '0) ? ST_DONE : ST_POPW;
			ST_POPW:  state_d = ST_DONE;
			ST_PUSH:  state_d = ST_DONE;
			ST_EXEC:  state_d = ST_DONE;
			ST_DONE:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		dir_rd_en   = 1'b0;
		dir_wr_en   = 1'b0;
		dir_wr_addr = rd_addr_s1;
		dir_wr_slot = rd_slot;
		dir_wr_pins = rd_pins;
		fl_ctl      = '0;
		fl_wr_addr  = fl_count[FA-1:0];
		fl_wr_data  = bidx_q;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_INIT: begin
				dir_wr_en   = issue;
				dir_wr_addr = sweep_q[SA-1:0];
				dir_wr_slot = '0;
				dir_wr_pins = '0;
				if (sweep_q < SW'(fill_n_q)) begin
					fl_ctl.write = 1'b1;
					fl_wr_addr   = sweep_q[FA-1:0];
					fl_wr_data   = BUF_W'(sweep_q);
				end
				fl_ctl.load = init_end;
			end
			ST_CLEAR: begin
				dir_rd_en = issue;
				if (rd_v_s1) begin
					dir_wr_en         = 1'b1;
					dir_wr_slot.valid = 1'b0;
					if (rd_slot.valid && rd_slot.has_buf && !fl_full) begin
						fl_ctl.write = 1'b1;
						fl_ctl.push  = 1'b1;
						fl_wr_data   = rd_slot.buffer;
					end
				end
			end
			ST_SCAN: dir_rd_en = issue;
			ST_POP:  fl_ctl.pop = (fl_count != '0);
			ST_PUSH: begin
				if (!absent_q && !fl_full) begin
					fl_ctl.write = 1'b1;
					fl_ctl.push  = 1'b1;
				end
			end
			ST_EXEC: begin
				dir_wr_addr = hit_idx_q;
				dir_wr_slot = hit_slot_q;
				if (hit_q && cmd_q == CMD_ENTER) begin
					dir_wr_en   = 1'b1;
					dir_wr_pins = (hit_pins_q == PIN_MAX) ? hit_pins_q
						: hit_pins_q + PIN_BITS'(1);
				end else if (hit_q && cmd_q == CMD_LEAVE && hit_pins_q != '0) begin
					dir_wr_en   = 1'b1;
					dir_wr_pins = hit_pins_q - PIN_BITS'(1);
				end else if (!hit_q && cmd_q == CMD_ADD && free_ok_q) begin
					dir_wr_en           = 1'b1;
					dir_wr_addr         = free_idx_q;
					dir_wr_slot.valid   = 1'b1;
					dir_wr_slot.page    = page_q;
					dir_wr_slot.has_buf = !absent_q;
					dir_wr_slot.buffer  = absent_q ? '0 : bidx_q;
					dir_wr_pins         = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			wipe_q      <= 1'b1;
			fill_n_q    <= '0;
			sweep_q     <= '0;
			pages_q     <= '0;
			rd_v_s1     <= 1'b0;
			hit_q       <= 1'b0;
			free_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= sweep_step && issue;
			if (psel && penable && pwrite && paddr[2] == 1'b0) begin
				pages_q <= pwdata[CFG_W-1:0];
			end
			if (accept) begin
				sweep_q   <= '0;
				hit_q     <= 1'b0;
				free_ok_q <= 1'b0;
				if (cmd_e_t'(cmd) == CMD_INIT) fill_n_q <= fill_n;
			end
			if (state_q == ST_INIT) begin
				if (init_end) wipe_q <= 1'b0;
				else sweep_q <= sweep_q + SW'(1);
			end
			if (sweep_step && issue) begin
				sweep_q <= sweep_q + SW'(1);
			end
			if (state_q == ST_SCAN) begin
				if (scan_hit) hit_q <= 1'b1;
				if (rd_v_s1 && !rd_slot.valid) free_ok_q <= 1'b1;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= sweep_q[SA-1:0];
		if (accept) begin
			cmd_q    <= cmd_e_t'(cmd);
			page_q   <= page_id;
			bidx_q   <= buffer_index;
			absent_q <= buffer_absent;
			res_q    <= '0;
		end
		if (out_load) out_res_q <= res_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (rd_v_s1 && rd_slot.valid && rd_slot.has_buf && fl_full) begin
					res_q.status <= STS_FREE_FULL;
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					hit_idx_q  <= rd_addr_s1;
					hit_slot_q <= rd_slot;
					hit_pins_q <= rd_pins;
				end
				// Keep the lowest empty slot for a later add.
				if (rd_v_s1 && !rd_slot.valid && !free_ok_q) free_idx_q <= rd_addr_s1;
			end
			ST_POP: if (fl_count == '0) res_q.status <= STS_MISS;
			ST_POPW: begin
				res_q.rvalid <= 1'b1;
				res_q.rbuf   <= fl_rd_data;
			end
			ST_PUSH: if (!absent_q && fl_full) res_q.status <= STS_FREE_FULL;
			ST_EXEC: begin
				res_q.found <= hit_q;
				case (cmd_q) inside
					CMD_ENTER, CMD_CONTAINS: begin
						if (!hit_q) res_q.status <= STS_MISS;
						else if (cmd_q == CMD_ENTER) begin
							res_q.rvalid <= hit_slot_q.has_buf;
							res_q.rbuf   <= hit_slot_q.has_buf ? hit_slot_q.buffer : '0;
						end
					end
					CMD_LEAVE: begin
						if (!hit_q) res_q.status <= STS_MISS;
						else if (hit_pins_q == '0) res_q.status <= STS_UNDERFLOW;
						else if (hit_pins_q == PIN_BITS'(1)) begin
							res_q.zev   <= 1'b1;
							res_q.zpage <= page_q;
						end
					end
					CMD_ADD: begin
						if (hit_q) begin
							res_q.rvalid <= hit_slot_q.has_buf;
							res_q.rbuf   <= hit_slot_q.has_buf ? hit_slot_q.buffer : '0;
						end else if (!free_ok_q) begin
							res_q.status <= STS_DIR_FULL;
						end else begin
							res_q.rvalid <= !absent_q;
							res_q.rbuf   <= absent_q ? '0 : bidx_q;
							res_q.zev    <= 1'b1;
							res_q.zpage  <= page_q;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign out_valid           = out_valid_q;
	assign status              = out_res_q.status;
	assign found               = out_res_q.found;
	assign result_valid_buffer = out_res_q.rvalid;
	assign result_buffer       = out_res_q.rbuf;
	assign zero_ref_event      = out_res_q.zev;
	assign zero_ref_page       = out_res_q.zpage;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(pages_q) : '0;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		fl_count <= FC'(NUM_BUFFERS))
		else $error("free list count beyond its depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fl_ctl.pop |-> fl_count != '0)
		else $error("pop from an empty free list");
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		fl_ctl.push |-> !fl_full)
		else $error("push onto a full free list");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request accepted while another is in progress");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for page_buffer_pool_with_pin_counts: an in-bench model of the
// free list and page directory predicts every result; a monitor compares them.
// Depends on pbp_pkg and the page_buffer_pool_with_pin_counts RTL.
module tb_top;
	import pbp_pkg::*;

	localparam int NBUF = 1024;
	localparam int NSLOT = 1024;
	localparam int unsigned PIN_MAX = 65535;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	cmd_e_t cmd = CMD_INIT;
	logic [PAGE_W-1:0] page_id = '0;
	logic [BUF_W-1:0] buffer_index = '0;
	logic buffer_absent = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic found;
	logic result_valid_buffer;
	logic [BUF_W-1:0] result_buffer;
	logic zero_ref_event;
	logic [PAGE_W-1:0] zero_ref_page;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	page_buffer_pool_with_pin_counts u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .page_id(page_id), .buffer_index(buffer_index),
		.buffer_absent(buffer_absent),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found(found), .result_valid_buffer(result_valid_buffer),
		.result_buffer(result_buffer), .zero_ref_event(zero_ref_event),
		.zero_ref_page(zero_ref_page),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Model state of the pool.
	logic [BUF_W-1:0] free_stk [NBUF];
	int free_cnt;
	bit dir_valid [NSLOT];
	logic [PAGE_W-1:0] dir_page [NSLOT];
	logic [BUF_W-1:0] dir_buf [NSLOT];
	bit dir_has_buf [NSLOT];
	int unsigned dir_pins [NSLOT];
	int unsigned pages_cfg;

	res_t expected_results [$];
	int errors = 0;
	int checked = 0;
	int cmd_seen [8];
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	logic [PAGE_W-1:0] hot_pages [12];

	initial forever #6 clk = ~clk;

	function automatic int find_page(logic [PAGE_W-1:0] pg);
		for (int i = 0; i < NSLOT; i++)
			if (dir_valid[i] && dir_page[i] == pg)
				return i;
		return -1;
	endfunction

	function automatic bit push_buffer(logic [BUF_W-1:0] b);
		if (free_cnt >= NBUF)
			return 1'b0;
		free_stk[free_cnt] = b;
		free_cnt++;
		return 1'b1;
	endfunction

	function automatic res_t pool_step(cmd_e_t c, logic [PAGE_W-1:0] pg,
			logic [BUF_W-1:0] b, logic absent);
		res_t r;
		int s;
		int n;
		r = '0;
		r.status = STS_OK;
		case (c)
			CMD_INIT: begin
				for (int i = 0; i < NSLOT; i++)
					dir_valid[i] = 1'b0;
				n = (pages_cfg < NBUF) ? pages_cfg : NBUF;
				for (int i = 0; i < n; i++)
					free_stk[i] = i[BUF_W-1:0];
				free_cnt = n;
			end
			CMD_CLEAR: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (dir_valid[i] && dir_has_buf[i] && !push_buffer(dir_buf[i]))
						r.status = STS_FREE_FULL;
					dir_valid[i] = 1'b0;
				end
			end
			CMD_ACQUIRE: begin
				if (free_cnt == 0) begin
					r.status = STS_MISS;
				end else begin
					free_cnt--;
					r.rvalid = 1'b1;
					r.rbuf = free_stk[free_cnt];
				end
			end
			CMD_RELEASE: begin
				if (!absent && !push_buffer(b))
					r.status = STS_FREE_FULL;
			end
			CMD_ENTER: begin
				s = find_page(pg);
				if (s < 0) begin
					r.status = STS_MISS;
				end else begin
					r.found = 1'b1;
					if (dir_pins[s] < PIN_MAX)
						dir_pins[s]++;
					r.rvalid = dir_has_buf[s];
					r.rbuf = dir_has_buf[s] ? dir_buf[s] : '0;
				end
			end
			CMD_CONTAINS: begin
				s = find_page(pg);
				if (s < 0)
					r.status = STS_MISS;
				else
					r.found = 1'b1;
			end
			CMD_LEAVE: begin
				s = find_page(pg);
				if (s < 0) begin
					r.status = STS_MISS;
				end else begin
					r.found = 1'b1;
					if (dir_pins[s] == 0) begin
						r.status = STS_UNDERFLOW;
					end else begin
						dir_pins[s]--;
						if (dir_pins[s] == 0) begin
							r.zev = 1'b1;
							r.zpage = pg;
						end
					end
				end
			end
			default: begin
				s = find_page(pg);
				if (s >= 0) begin
					r.found = 1'b1;
					r.rvalid = dir_has_buf[s];
					r.rbuf = dir_has_buf[s] ? dir_buf[s] : '0;
				end else begin
					s = -1;
					for (int i = 0; i < NSLOT && s < 0; i++)
						if (!dir_valid[i])
							s = i;
					if (s < 0) begin
						r.status = STS_DIR_FULL;
					end else begin
						dir_valid[s] = 1'b1;
						dir_page[s] = pg;
						dir_has_buf[s] = !absent;
						dir_buf[s] = absent ? '0 : b;
						dir_pins[s] = 0;
						r.rvalid = !absent;
						r.rbuf = dir_buf[s];
						r.zev = 1'b1;
						r.zpage = pg;
					end
				end
			end
		endcase
		return r;
	endfunction

	// Sends one request; valid is only lowered when a gap is taken.
	task automatic send_request(cmd_e_t c, logic [PAGE_W-1:0] pg = '0,
			logic [BUF_W-1:0] b = '0, logic absent = 1'b0);
		res_t exp_r;
		if (!calm && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 40);
		end
		in_valid <= 1'b1;
		cmd <= c;
		page_id <= pg;
		buffer_index <= b;
		buffer_absent <= absent;
		do @(posedge clk); while (!in_ready);
		exp_r = pool_step(c, pg, b, absent);
		expected_results = {expected_results, exp_r};
		cmd_seen[c]++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_pages(int unsigned v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= '0;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pages_cfg = v & 32'h7ff;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result with no request pending, expected none, got status %0d",
					$time, status);
			end else begin
				e = expected_results.pop_front();
				checked++;
				check_field("status", e.status, status);
				check_field("found", e.found, found);
				check_field("result_valid_buffer", e.rvalid, result_valid_buffer);
				check_field("result_buffer", e.rbuf, result_buffer);
				check_field("zero_ref_event", e.zev, zero_ref_event);
				check_field("zero_ref_page", e.zpage, zero_ref_page);
			end
		end
	end

	// Receiver side: random stalls, plus a long hold when asked for.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= 29);
			end
		end
	end

	initial begin
		#150000000;
		$display("tb_top NOT OK");
		$finish;
	end

	// Everything should miss or be empty right after reset.
	task automatic test_empty_pool;
		send_request(CMD_ACQUIRE);
		send_request(CMD_CONTAINS, 32'h0);
		send_request(CMD_ENTER, 32'hffff_ffff);
		send_request(CMD_LEAVE, 32'h1234_5678);
		send_request(CMD_RELEASE, 32'h0, 10'h3ff, 1'b1);
		send_request(CMD_CLEAR);
		drain();
	endtask

	task automatic test_free_list;
		write_pages(3);
		send_request(CMD_INIT);
		repeat (4) send_request(CMD_ACQUIRE);
		send_request(CMD_RELEASE, 32'h0, 10'h3ff, 1'b0);
		send_request(CMD_RELEASE, 32'h0, 10'h000, 1'b0);
		send_request(CMD_ACQUIRE);
		drain();
	endtask

	task automatic test_directory;
		send_request(CMD_ADD, 32'hffff_ffff, 10'h2aa, 1'b0);
		send_request(CMD_ADD, 32'hffff_ffff, 10'h155, 1'b0);
		send_request(CMD_ADD, 32'h0, 10'h3ff, 1'b1);
		send_request(CMD_ENTER, 32'hffff_ffff);
		send_request(CMD_ENTER, 32'h0);
		send_request(CMD_LEAVE, 32'hffff_ffff);
		send_request(CMD_LEAVE, 32'hffff_ffff);
		send_request(CMD_CONTAINS, 32'h0);
		send_request(CMD_CLEAR);
		drain();
	endtask

	// A full free list drops releases and the overflow of a clear.
	task automatic test_free_list_full;
		write_pages(1024);
		send_request(CMD_INIT);
		send_request(CMD_RELEASE, 32'h0, 10'h155, 1'b0);
		send_request(CMD_ADD, 32'h8000_0001, 10'h011, 1'b0);
		send_request(CMD_ADD, 32'h8000_0002, 10'h022, 1'b1);
		send_request(CMD_CLEAR);
		send_request(CMD_ACQUIRE);
		send_request(CMD_CLEAR);
		drain();
	endtask

	// The receiver holds off while requests keep coming, so the input stalls.
	task automatic test_output_stall;
		hold_req = 1'b1;
		for (int i = 0; i < 6; i++)
			send_request(CMD_ADD, hot_pages[i], 10'($urandom_range(0, 1023)), 1'b0);
		drain();
	endtask

	task automatic test_random_mix;
		int pick;
		logic [PAGE_W-1:0] pg;
		for (int i = 0; i < 370; i++) begin
			calm = (i >= 150 && i < 250);
			if (i == 200) begin
				drain();
				write_pages(5);
			end
			pick = $urandom_range(0, 99);
			pg = ($urandom_range(0, 99) < 85) ? hot_pages[$urandom_range(0, 11)]
				: $urandom;
			if (pick < 2)
				send_request(CMD_INIT);
			else if (pick < 5)
				send_request(CMD_CLEAR);
			else if (pick < 15)
				send_request(CMD_ACQUIRE);
			else if (pick < 25)
				send_request(CMD_RELEASE, pg, 10'($urandom_range(0, 1023)),
					$urandom_range(0, 9) == 0);
			else if (pick < 50)
				send_request(CMD_ENTER, pg);
			else if (pick < 60)
				send_request(CMD_CONTAINS, pg);
			else if (pick < 80)
				send_request(CMD_LEAVE, pg);
			else
				send_request(CMD_ADD, pg, 10'($urandom_range(0, 1023)),
					$urandom_range(0, 4) == 0);
		end
		calm = 1'b0;
		drain();
	endtask

	initial begin
		hot_pages[0] = 32'h0;
		hot_pages[1] = 32'hffff_ffff;
		for (int i = 2; i < 12; i++)
			hot_pages[i] = $urandom;
		pages_cfg = 0;
		free_cnt = 0;
		for (int i = 0; i < NSLOT; i++)
			dir_valid[i] = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		write_pages(0);
		test_empty_pool();
		test_free_list();
		test_directory();
		test_free_list_full();
		write_pages(17);
		send_request(CMD_INIT);
		drain();
		test_output_stall();
		test_random_mix();
		repeat (20) @(posedge clk);
		$display("Requests per command init..add: %0d %0d %0d %0d %0d %0d %0d %0d",
			cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3],
			cmd_seen[4], cmd_seen[5], cmd_seen[6], cmd_seen[7]);
		$display("%0d results checked, %0d mismatches", checked, errors);
		if (errors == 0 && expected_results.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule

FILE: files.f
rtl/pbp_pkg.sv
rtl/pbp_free_list.sv
rtl/pbp_directory.sv
rtl/page_buffer_pool_with_pin_counts.sv
bench/tb_top.sv
